// ===== hw/rtl/bsc_pkg.sv =====
package bsc_pkg;

    // Default stack size in entries
    localparam int STACK_DEPTH_DEF = 64;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Width of the depth result field
    localparam int DEPTH_W = 7;

    // Character classes: an even class opens, the next odd class closes it
    localparam int CLS_W = 4;
    localparam logic [CLS_W-1:0] CLS_PAREN_OPEN  = 4'd0;
    localparam logic [CLS_W-1:0] CLS_PAREN_CLOSE = 4'd1;
    localparam logic [CLS_W-1:0] CLS_SQUARE_OPEN  = 4'd2;
    localparam logic [CLS_W-1:0] CLS_SQUARE_CLOSE = 4'd3;
    localparam logic [CLS_W-1:0] CLS_CURLY_OPEN  = 4'd4;
    localparam logic [CLS_W-1:0] CLS_CURLY_CLOSE = 4'd5;
    localparam logic [CLS_W-1:0] CLS_ANGLE_OPEN  = 4'd6;
    localparam logic [CLS_W-1:0] CLS_ANGLE_CLOSE = 4'd7;
    localparam logic [CLS_W-1:0] CLS_OTHER       = 4'd8;

    // Classified item as it travels from front to back
    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic             last;
    } t_op;

    // Map a character byte to its class
    function automatic logic [CLS_W-1:0] classify(input logic [7:0] ch);
        logic [CLS_W-1:0] cls;
        begin
            case (ch)
                8'h28:   cls = CLS_PAREN_OPEN;    // (
                8'h29:   cls = CLS_PAREN_CLOSE;   // )
                8'h5B:   cls = CLS_SQUARE_OPEN;   // [
                8'h5D:   cls = CLS_SQUARE_CLOSE;  // ]
                8'h7B:   cls = CLS_CURLY_OPEN;    // {
                8'h7D:   cls = CLS_CURLY_CLOSE;   // }
                8'h3C:   cls = CLS_ANGLE_OPEN;    // <
                8'h3E:   cls = CLS_ANGLE_CLOSE;   // >
                default: cls = CLS_OTHER;
            endcase
            return cls;
        end
    endfunction

endpackage

// ===== hw/rtl/bsc_front.sv =====
module bsc_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [7:0]   i_ch,
    input  logic         i_last,
    output logic         o_op_valid,
    input  logic         i_op_ready,
    output bsc_pkg::t_op o_op
);
    import bsc_pkg::*;

    t_op                    r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_fill;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_fill;
    logic                   push;
    logic                   pop;
    t_op                    op_in;

    // Classify the incoming byte
    always_comb begin
        op_in.cls  = classify(i_ch);
        op_in.last = i_last;
    end

    assign o_in_ready = (r_fill != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_op_valid = (r_fill != '0);
    assign o_op       = r_slot[r_rd_ptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = o_op_valid && i_op_ready;

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : r_wr_ptr + QUEUE_PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : r_rd_ptr + QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            n_fill = r_fill + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            n_fill = r_fill - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the classified item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= op_in;
        end
    end

endmodule

// ===== hw/rtl/bsc_back.sv =====
module bsc_back #(
    parameter int STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_op_valid,
    output logic                      o_op_ready,
    input  bsc_pkg::t_op              i_op,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [bsc_pkg::DEPTH_W-1:0] o_depth,
    output logic                      o_done_res,
    output logic                      o_balanced,
    output logic                      o_overflow
);
    import bsc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Stack entries, top also held in r_top
    logic [CLS_W-1:0] r_mem [STACK_DEPTH];
    logic [CLS_W-1:0] r_top;
    logic [CLS_W-1:0] r_below;
    logic [CLS_W-1:0] n_top;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CW-1:0]    step_count;
    logic             r_ovf;
    logic             n_ovf;
    logic             step_ovf;
    logic [CW-1:0]    rd_sub;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic             fire;
    logic             pops;
    logic             full;
    logic             step_bal;
    logic [CW+DEPTH_W-1:0] depth_ext;

    // Output register
    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_depth;
    logic               r_done;
    logic               r_bal;
    logic               r_ovf_out;

    assign o_op_ready = !r_out_valid || i_out_ready;
    assign fire       = i_op_valid && o_op_ready;
    assign full       = (r_count == CW'(STACK_DEPTH));

    // Pop only when the item closes the class on top
    assign pops = (r_count != '0) && !i_op.cls[CLS_W-1] && i_op.cls[0]
               && !r_top[CLS_W-1] && (i_op.cls == r_top + CLS_W'(1));

    // Update the stack for one item
    always_comb begin
        step_count = r_count;
        step_ovf   = r_ovf;
        n_top      = r_top;
        wr_en      = 1'b0;
        if (fire) begin
            if (pops) begin
                step_count = r_count - CW'(1);
                n_top      = r_below;
            end else if (full) begin
                step_ovf = 1'b1;
            end else begin
                step_count = r_count + CW'(1);
                n_top      = i_op.cls;
                wr_en      = 1'b1;
            end
        end
        step_bal = (step_count == '0) && !step_ovf;
        n_count  = step_count;
        n_ovf    = step_ovf;
        if (fire && i_op.last) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    // Prefetch the entry under the next top
    assign rd_sub  = n_count - CW'(2);
    assign rd_addr = rd_sub[AW-1:0];
    assign wr_addr = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_op.cls;
        end
        r_below <= r_mem[rd_addr];
        r_top   <= n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Hold the result until taken
    assign depth_ext = {{DEPTH_W{1'b0}}, step_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_depth   <= depth_ext[DEPTH_W-1:0];
            r_done    <= i_op.last;
            r_bal     <= i_op.last && step_bal;
            r_ovf_out <= step_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_depth     = r_depth;
    assign o_done_res  = r_done;
    assign o_balanced  = r_bal;
    assign o_overflow  = r_ovf_out;

endmodule

// ===== hw/rtl/bracket_sequence_checker.sv =====
// Bracket sequence checker: takes one character byte per item and returns one result
// per item, one item per clock while results are taken as they come; an accepted item
// passes the front's queue and the back's output register before its result is valid.
// The front classifies each byte and holds it in a two-entry queue; the back keeps the
// top of the class stack in a register and prefetches the entry below it from the stack
// memory's registered read port every cycle, so a push, a pop or a dropped push needs no
// wait for a memory read. On the item marked last the result reports balanced when the
// stack is empty and nothing overflowed, and the stack and sticky overflow flag clear
// for the next string. No clearing pass runs after reset; items are taken at once.
module bracket_sequence_checker #(
    parameter int STACK_DEPTH = bsc_pkg::STACK_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_ch,
    input  logic                        i_last,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bsc_pkg::DEPTH_W-1:0] o_depth,
    output logic                        o_done_res,
    output logic                        o_balanced,
    output logic                        o_overflow
);
    import bsc_pkg::*;

    logic op_valid;
    logic op_ready;
    t_op  op;

    // Classify and queue
    bsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ch       (i_ch),
        .i_last     (i_last),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    // Run the stack
    bsc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_depth     (o_depth),
        .o_done_res  (o_done_res),
        .o_balanced  (o_balanced),
        .o_overflow  (o_overflow)
    );

    // A balanced report only closes a string with an empty stack and no overflow
    a_balanced_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_balanced |-> o_done_res && (o_depth == '0) && !o_overflow)
        else $error("balanced reported without closing an empty, clean stack");

    // A full queue always offers an item to the back
    a_queue_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> op_valid)
        else $error("input stalled while queue is empty");

    // The back takes an item whenever the output register is free
    a_back_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> op_ready)
        else $error("back stalled with free output register");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import bsc_pkg::*;

    localparam int STACK_SIZE  = bsc_pkg::STACK_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1440;
    localparam int SETTLE_CYC  = 16;

    // Bracket kinds, in class order: paren, square, curly, angle
    localparam int KIND_PAREN  = 0;
    localparam int KIND_SQUARE = 1;
    localparam int KIND_CURLY  = 2;
    localparam int KIND_ANGLE  = 3;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;   // hold this item until every result is back
    } t_char_item;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic               done_res;
        logic               balanced;
        logic               overflow;
    } t_scan_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [7:0]         i_ch        = 8'h00;
    logic               i_last      = 1'b0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [DEPTH_W-1:0] o_depth;
    logic               o_done_res;
    logic               o_balanced;
    logic               o_overflow;

    t_char_item   pending_chars[$];
    t_scan_result scan_results_due[$];

    // Shadow of the class stack
    logic [CLS_W-1:0] shadow_stack [STACK_SIZE];
    int               shadow_count = 0;
    bit               shadow_ovf   = 1'b0;

    int           cycle_count = 0;
    int           error_count = 0;
    int           send_gap    = 0;
    int           recv_gap    = 0;
    t_char_item   next_item;
    t_scan_result got_exp;

    bracket_sequence_checker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_ch        (i_ch),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_depth     (o_depth),
        .o_done_res  (o_done_res),
        .o_balanced  (o_balanced),
        .o_overflow  (o_overflow)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (((cycle_count >> 9) & 3) == 3) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CLS_W-1:0] char_class(input logic [7:0] ch);
        case (ch)
            8'h28:   return CLS_PAREN_OPEN;
            8'h29:   return CLS_PAREN_CLOSE;
            8'h5B:   return CLS_SQUARE_OPEN;
            8'h5D:   return CLS_SQUARE_CLOSE;
            8'h7B:   return CLS_CURLY_OPEN;
            8'h7D:   return CLS_CURLY_CLOSE;
            8'h3C:   return CLS_ANGLE_OPEN;
            8'h3E:   return CLS_ANGLE_CLOSE;
            default: return CLS_OTHER;
        endcase
    endfunction

    function automatic logic [7:0] bracket_char(input int kind, input bit closing);
        case (kind)
            KIND_PAREN:  return closing ? 8'h29 : 8'h28;
            KIND_SQUARE: return closing ? 8'h5D : 8'h5B;
            KIND_CURLY:  return closing ? 8'h7D : 8'h7B;
            default:     return closing ? 8'h3E : 8'h3C;
        endcase
    endfunction

    // Push a class, or drop it and raise the sticky flag when full
    task automatic shadow_push(input logic [CLS_W-1:0] cls);
        if (shadow_count < STACK_SIZE) begin
            shadow_stack[shadow_count] = cls;
            shadow_count++;
        end else begin
            shadow_ovf = 1'b1;
        end
    endtask

    // Advance the shadow stack by one character and queue its result
    task automatic scan_char(input logic [7:0] ch, input logic last);
        logic [CLS_W-1:0] cls;
        logic [CLS_W-1:0] top;
        bit               pops;
        t_scan_result     res;
        cls = char_class(ch);
        if (shadow_count == 0) begin
            shadow_push(cls);
        end else begin
            top  = shadow_stack[shadow_count-1];
            pops = (cls != CLS_OTHER) && cls[0] && (top != CLS_OTHER) &&
                   (cls == top + 1'b1);
            if (pops) shadow_count--;
            else shadow_push(cls);
        end
        res.depth    = shadow_count[DEPTH_W-1:0];
        res.done_res = last;
        res.overflow = shadow_ovf;
        res.balanced = 1'b0;
        if (last) begin
            res.balanced = (shadow_count == 0) && !shadow_ovf;
            shadow_count = 0;
            shadow_ovf   = 1'b0;
        end
        scan_results_due = {scan_results_due, res};
    endtask

    task automatic add_char(input logic [7:0] ch, input logic last, input bit drain);
        t_char_item it;
        it.ch    = ch;
        it.last  = last;
        it.drain = drain;
        pending_chars = {pending_chars, it};
    endtask

    task automatic add_string(input logic [7:0] str[$], input bit drain);
        int i;
        for (i = 0; i < str.size(); i++)
            add_char(str[i], i == str.size() - 1, drain && (i == 0));
    endtask

    // Random well-formed nesting, optionally broken in one place
    task automatic add_nested(input int pairs, input bit corrupt, input bit drain);
        int         open_kinds[$];
        logic [7:0] str[$];
        int         opens_left;
        int         k;
        int         pos;
        opens_left = pairs;
        while (opens_left > 0 || open_kinds.size() > 0) begin
            if (open_kinds.size() == 0 || (opens_left > 0 && $urandom_range(0, 1))) begin
                k = $urandom_range(0, 3);
                open_kinds = {open_kinds, k};
                str = {str, bracket_char(k, 1'b0)};
                opens_left--;
            end else begin
                k = open_kinds.pop_back();
                str = {str, bracket_char(k, 1'b1)};
            end
        end
        if (corrupt) begin
            pos = $urandom_range(0, str.size() - 1);
            case ($urandom_range(0, 3))
                0: str[pos] = 8'($urandom_range(0, 255));
                1: str[pos] = bracket_char($urandom_range(0, 3), 1'($urandom_range(0, 1)));
                2: if (str.size() > 1) str.delete(pos);
                default: str.insert(pos, bracket_char($urandom_range(0, 3), 1'b1));
            endcase
        end
        add_string(str, drain);
    endtask

    // Fill the stack to the top, push extra characters that get dropped, unwind
    task automatic add_full_stack(input int extra);
        int         kinds[$];
        logic [7:0] str[$];
        int         i;
        int         k;
        for (i = 0; i < STACK_SIZE; i++) begin
            k = $urandom_range(0, 3);
            kinds = {kinds, k};
            str = {str, bracket_char(k, 1'b0)};
        end
        for (i = 0; i < extra; i++) begin
            if ($urandom_range(0, 1)) str = {str, 8'($urandom_range(0, 255))};
            else str = {str, bracket_char($urandom_range(0, 3), 1'b0)};
        end
        while (kinds.size() > 0)
            str = {str, bracket_char(kinds.pop_back(), 1'b1)};
        add_string(str, 1'b0);
    endtask

    // Random bytes and brackets, with end marks anywhere
    task automatic add_noise(input int len);
        int         i;
        logic [7:0] ch;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 1)) ch = 8'($urandom_range(0, 255));
            else ch = bracket_char($urandom_range(0, 3), 1'($urandom_range(0, 1)));
            add_char(ch, (i == len - 1) || ($urandom_range(0, 4) == 0), 1'b0);
        end
    endtask

    // Driver: predict each accepted item, then present the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_ch       <= 8'h00;
            i_last     <= 1'b0;
            send_gap   = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                scan_char(i_ch, i_last);
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_chars.size() > 0 &&
                             !(pending_chars[0].drain && scan_results_due.size() != 0)) begin
                    next_item = pending_chars.pop_front();
                    i_in_valid <= 1'b1;
                    i_ch       <= next_item.ch;
                    i_last     <= next_item.last;
                    send_gap   = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result, then pick the next stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap    = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (scan_results_due.size() == 0) begin
                    $error("result with no item pending: depth %0d", o_depth);
                    error_count++;
                end else begin
                    got_exp = scan_results_due.pop_front();
                    if (o_depth !== got_exp.depth) begin
                        $error("depth: expected %0d, got %0d", got_exp.depth, o_depth);
                        error_count++;
                    end
                    if (o_done_res !== got_exp.done_res) begin
                        $error("done_res: expected %0d, got %0d", got_exp.done_res,
                               o_done_res);
                        error_count++;
                    end
                    if (o_balanced !== got_exp.balanced) begin
                        $error("balanced: expected %0d, got %0d", got_exp.balanced,
                               o_balanced);
                        error_count++;
                    end
                    if (o_overflow !== got_exp.overflow) begin
                        $error("overflow: expected %0d, got %0d", got_exp.overflow,
                               o_overflow);
                        error_count++;
                    end
                end
                recv_gap = pick_gap();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int strings;
        int r;
        bit drain;

        // Directed: single brackets, every pair, closers on empty, mismatches
        add_char(8'h28, 1'b1, 1'b0);                              // lone opener
        add_char(8'h28, 1'b0, 1'b0); add_char(8'h29, 1'b1, 1'b0);
        add_char(8'h5B, 1'b0, 1'b0); add_char(8'h5D, 1'b1, 1'b0);
        add_char(8'h7B, 1'b0, 1'b0); add_char(8'h7D, 1'b1, 1'b0);
        add_char(8'h3C, 1'b0, 1'b0); add_char(8'h3E, 1'b1, 1'b0);
        add_char(8'h29, 1'b1, 1'b0);                              // closer on empty
        add_char(8'h28, 1'b0, 1'b0); add_char(8'h5D, 1'b1, 1'b0); // wrong partner
        add_char(8'h00, 1'b1, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0);
        // other character blocks the match below it
        add_char(8'h28, 1'b0, 1'b0); add_char(8'h61, 1'b0, 1'b0);
        add_char(8'h29, 1'b1, 1'b0);
        add_char(8'h3C, 1'b0, 1'b0); add_char(8'h7B, 1'b0, 1'b0);
        add_char(8'h5B, 1'b0, 1'b0); add_char(8'h28, 1'b0, 1'b0);
        add_char(8'h29, 1'b0, 1'b0); add_char(8'h5D, 1'b0, 1'b0);
        add_char(8'h7D, 1'b0, 1'b0); add_char(8'h3E, 1'b1, 1'b0);

        // Full stack exactly, then dropped pushes followed by closers
        add_full_stack(0);
        add_full_stack(1);
        add_full_stack($urandom_range(2, 5));

        // Random strings, mostly well formed
        strings = 0;
        while (pending_chars.size() < ITEM_TARGET) begin
            drain = (strings % 30 == 0);
            r = $urandom_range(0, 99);
            if (r < 55) add_nested($urandom_range(1, 6), 1'b0, drain);
            else if (r < 70) add_nested($urandom_range(1, 6), 1'b1, drain);
            else if (r < 76) add_nested($urandom_range(10, 30), 1'($urandom_range(0, 1)),
                                        drain);
            else if (r < 78) add_full_stack($urandom_range(0, 4));
            else add_noise($urandom_range(1, 10));
            strings++;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sample between edges so the driver and monitor have settled
        while (pending_chars.size() != 0 || i_in_valid || scan_results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
